>>> rtl/core/pgmp_pkg.sv
// Shared types, codes and character helpers for the greymap text parser.
package pgmp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Final status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FORMAT = 2'd1;
  localparam logic [1:0] ST_SIZE   = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_2     = 8'h32;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_file;
  } pgmp_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] value;
    logic [11:0] column;
    logic [11:0] row;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic [1:0]  status;
    logic        last_result;
  } pgmp_out_t;

  // Up to two results caused by one byte
  typedef struct packed {
    pgmp_out_t  first;
    pgmp_out_t  second;
    logic [1:0] count;
  } pgmp_pair_t;

  function automatic logic is_space(logic [7:0] c);
    // space, tab, LF, VT, FF, CR
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic pgmp_out_t make_res(logic [1:0] kind, logic [15:0] value,
                                         logic [11:0] column, logic [11:0] row,
                                         logic [12:0] img_w, logic [12:0] img_h,
                                         logic [1:0] status);
    pgmp_out_t r;
    r.kind         = kind;
    r.value        = value;
    r.column       = column;
    r.row          = row;
    r.image_width  = img_w;
    r.image_height = img_h;
    r.status       = status;
    r.last_result  = 1'b0;
    return r;
  endfunction

endpackage

>>> rtl/core/pgm_ascii_stream_parser_core.sv
// Top level of the greymap text parser: input register, parser step, result queue.
//
// Channel  Direction  Handshake                  Payload
// in       sink       in_valid_i / in_stall_o    pgmp_in_t: one byte, end-of-file flag
// out      source     out_valid_o / out_stall_i  pgmp_out_t: one result
//
// One byte is taken per cycle while in_stall_o is low; the parser step for a byte is
// combinational logic between the input register and the two-entry result queue.
// A result passes the input register and then the result queue before it shows on
// out; a byte that gives two results occupies the output for two transfers.
// in_stall_o rises only when the input register holds a byte and the result queue
// is full; it comes from registers alone.
// Reset returns the parser to the start of a file; no clearing pass is needed.
module pgm_ascii_stream_parser_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int VALUE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pgmp_pkg::pgmp_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pgmp_pkg::pgmp_out_t out_data_o
);
  import pgmp_pkg::*;

  logic       in_valid_q;
  pgmp_in_t   in_q;
  logic       accept, advance, fifo_full;
  pgmp_pair_t pair;

  assign advance    = in_valid_q && !fifo_full;
  assign in_stall_o = in_valid_q && fifo_full;
  assign accept     = in_valid_i && !in_stall_o;

  // Hold the incoming byte
  always_ff @(posedge clk_i) begin
    if (accept) in_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  pgmp_engine #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .VALUE_BITS (VALUE_BITS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .in_i   (in_q),
    .pair_o (pair)
  );

  pgmp_pair_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (advance && (pair.count != 2'd0)),
    .pair_i      (pair),
    .full_o      (fifo_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/core/pgmp_engine.sv
// Parser state and the single-pass per-byte step logic.
module pgmp_engine #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096,
  parameter int VALUE_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  pgmp_pkg::pgmp_in_t  in_i,
  output pgmp_pkg::pgmp_pair_t pair_o
);
  import pgmp_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int AW0 = (WW > HW) ? WW : HW;
  // accumulator saturates above every limit
  localparam int AW  = (AW0 > VALUE_BITS) ? AW0 : VALUE_BITS;

  localparam logic [AW-1:0] LIM_W = AW'(MAX_WIDTH);
  localparam logic [AW-1:0] LIM_H = AW'(MAX_HEIGHT);
  localparam logic [AW-1:0] VMAX  = AW'({VALUE_BITS{1'b1}});

  localparam logic [2:0] PH_MAGIC_P = 3'd0;
  localparam logic [2:0] PH_MAGIC_2 = 3'd1;
  localparam logic [2:0] PH_WIDTH   = 3'd2;
  localparam logic [2:0] PH_HEIGHT  = 3'd3;
  localparam logic [2:0] PH_MAXVAL  = 3'd4;
  localparam logic [2:0] PH_PIXELS  = 3'd5;
  localparam logic [2:0] PH_TRAIL   = 3'd6;
  localparam logic [2:0] PH_FLUSH   = 3'd7;

  typedef struct packed {
    logic [2:0]            phase;
    logic                  in_number;
    logic                  negative_sign;
    logic                  seen_digit;
    logic [AW-1:0]         acc;
    logic                  too_big;
    logic [WW-1:0]         width;
    logic [HW-1:0]         height;
    logic [VALUE_BITS-1:0] maxval;
    logic [WW-1:0]         col;
    logic [HW-1:0]         row;
  } eng_state_t;

  typedef struct packed {
    eng_state_t st;
    pgmp_pair_t res;
    logic       ok;
  } work_t;

  eng_state_t state_q, state_d;
  work_t      w_c;

  function automatic eng_state_t idle_state();
    eng_state_t s;
    s       = '0;
    s.phase = PH_MAGIC_P;
    return s;
  endfunction

  // Append a result; a third one is dropped
  function automatic work_t emit(work_t w, pgmp_out_t r);
    work_t o;
    o = w;
    if (w.res.count == 2'd0) begin
      o.res.first = r;
    end else if (w.res.count == 2'd1) begin
      o.res.second = r;
    end
    if (w.res.count != 2'd2) begin
      o.res.count = w.res.count + 2'd1;
    end
    return o;
  endfunction

  function automatic work_t fail(work_t w, logic [1:0] code);
    work_t o;
    o = emit(w, make_res(KIND_STATUS, '0, '0, '0, '0, '0, code));
    o.st.phase     = PH_FLUSH;
    o.st.in_number = 1'b0;
    o.ok           = 1'b0;
    return o;
  endfunction

  // Complete the number in progress and check it against the current field
  function automatic work_t finish(work_t w);
    work_t         o;
    logic          neg;
    logic [AW-1:0] mag;
    logic [31:0]   mag32, w32, h32, c32, r32;
    logic [WW-1:0] col_nx;
    logic [HW-1:0] row_nx;
    o              = w;
    o.ok           = 1'b1;
    o.st.in_number = 1'b0;
    mag    = w.st.acc;
    neg    = w.st.negative_sign && (mag != '0);
    mag32  = 32'(mag);
    w32    = 32'(w.st.width);
    h32    = 32'(w.st.height);
    c32    = 32'(w.st.col);
    r32    = 32'(w.st.row);
    col_nx = w.st.col + WW'(1);
    row_nx = w.st.row + HW'(1);
    if (!w.st.seen_digit) begin
      o = fail(o, ST_FORMAT);
    end else begin
      unique case (w.st.phase)
        PH_WIDTH: begin
          if (w.st.negative_sign || (mag == '0)) begin
            o = fail(o, ST_FORMAT);
          end else if (w.st.too_big || (mag > LIM_W)) begin
            o = fail(o, ST_SIZE);
          end else begin
            o.st.width = mag[WW-1:0];
            o.st.phase = PH_HEIGHT;
          end
        end
        PH_HEIGHT: begin
          if (w.st.negative_sign || (mag == '0)) begin
            o = fail(o, ST_FORMAT);
          end else if (w.st.too_big || (mag > LIM_H)) begin
            o = fail(o, ST_SIZE);
          end else begin
            o.st.height = mag[HW-1:0];
            o.st.phase  = PH_MAXVAL;
          end
        end
        PH_MAXVAL: begin
          if (neg) begin
            o = fail(o, ST_FORMAT);
          end else if (w.st.too_big || (mag > VMAX)) begin
            o = fail(o, ST_SIZE);
          end else begin
            o.st.maxval = mag[VALUE_BITS-1:0];
            o = emit(o, make_res(KIND_HEADER, mag32[15:0], '0, '0,
                                 w32[12:0], h32[12:0], ST_OK));
            o.st.col   = '0;
            o.st.row   = '0;
            o.st.phase = PH_PIXELS;
          end
        end
        default: begin
          if (neg || w.st.too_big || (mag > AW'(w.st.maxval))) begin
            o = fail(o, ST_FORMAT);
          end else begin
            o = emit(o, make_res(KIND_PIXEL, mag32[15:0], c32[11:0], r32[11:0],
                                 '0, '0, ST_OK));
            if (col_nx >= w.st.width) begin
              o.st.col = '0;
              o.st.row = row_nx;
              if (row_nx >= w.st.height) begin
                o.st.phase = PH_TRAIL;
              end
            end else begin
              o.st.col = col_nx;
            end
          end
        end
      endcase
    end
    return o;
  endfunction

  // Examine one character; a character that ends a number is examined again
  function automatic work_t take_char(work_t w, logic [7:0] c);
    work_t           o;
    logic            dig, spc, sgn;
    logic [AW+3:0]   prod;
    o    = w;
    dig  = is_digit(c);
    spc  = is_space(c);
    sgn  = (c == CH_PLUS) || (c == CH_MINUS);
    prod = (AW+4)'({w.st.acc, 3'b000}) + (AW+4)'({w.st.acc, 1'b0}) + (AW+4)'(c[3:0]);
    unique case (w.st.phase)
      PH_MAGIC_P: begin
        if (c == CH_P) o.st.phase = PH_MAGIC_2;
        else o = fail(o, ST_FORMAT);
      end
      PH_MAGIC_2: begin
        if (c == CH_2) o.st.phase = PH_WIDTH;
        else o = fail(o, ST_FORMAT);
      end
      PH_TRAIL: begin
        if (!spc) o = fail(o, ST_FORMAT);
      end
      PH_FLUSH: begin
        o.ok = 1'b1;
      end
      default: begin
        if (w.st.in_number && dig) begin
          // accumulate one decimal digit, saturating
          if (prod[AW+3:AW] != '0) begin
            o.st.acc     = '1;
            o.st.too_big = 1'b1;
          end else begin
            o.st.acc = prod[AW-1:0];
          end
          o.st.seen_digit = 1'b1;
        end else begin
          if (w.st.in_number) o = finish(o);
          else o.ok = 1'b1;
          if (o.ok) begin
            if (o.st.phase == PH_TRAIL) begin
              if (!spc) o = fail(o, ST_FORMAT);
            end else if (spc) begin
              o.ok = 1'b1;
            end else if (sgn || dig) begin
              o.st.in_number     = 1'b1;
              o.st.negative_sign = (c == CH_MINUS);
              o.st.seen_digit    = dig;
              o.st.acc           = dig ? AW'(c[3:0]) : '0;
              o.st.too_big       = 1'b0;
            end else begin
              o = fail(o, ST_FORMAT);
            end
          end
        end
      end
    endcase
    return o;
  endfunction

  // Step the parser by one byte, then close the file on its final byte
  always_comb begin
    w_c       = '0;
    w_c.st    = state_q;
    w_c.ok    = 1'b1;
    w_c       = take_char(w_c, in_i.byte_in);
    if (in_i.end_of_file) begin
      if (w_c.st.phase != PH_FLUSH) begin
        w_c.ok = 1'b1;
        if (w_c.st.in_number) w_c = finish(w_c);
        if (w_c.ok) begin
          if (w_c.st.phase == PH_TRAIL) begin
            w_c = emit(w_c, make_res(KIND_STATUS, '0, '0, '0, '0, '0, ST_OK));
          end else begin
            w_c = fail(w_c, ST_FORMAT);
          end
        end
      end
      w_c.st = idle_state();
    end
  end

  // Mark the last result of this byte
  always_comb begin
    pair_o = w_c.res;
    if (w_c.res.count == 2'd1) begin
      pair_o.first.last_result = 1'b1;
    end else if (w_c.res.count == 2'd2) begin
      pair_o.second.last_result = 1'b1;
    end
  end

  assign state_d = step_i ? w_c.st : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= idle_state();
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/pgmp_pair_fifo.sv
// Two-entry queue of result pairs, unloaded one result per transfer.
module pgmp_pair_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  pgmp_pkg::pgmp_pair_t pair_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pgmp_pkg::pgmp_out_t  out_data_o
);
  import pgmp_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  pgmp_pair_t    entries_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q, count_d;
  logic          sub_q;
  pgmp_pair_t    head;
  logic          xfer, pop;

  assign head        = entries_q[rd_ptr_q];
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = sub_q ? head.second : head.first;
  assign full_o      = (count_q == CW'(DEPTH));

  // Release the entry once its last result is taken
  assign xfer = out_valid_o && !out_stall_i;
  assign pop  = xfer && (sub_q || (head.count != 2'd2));

  always_comb begin
    count_d = count_q;
    if (push_i && !pop) count_d = count_q + CW'(1);
    else if (!push_i && pop) count_d = count_q - CW'(1);
  end

  // Store pairs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= pair_i;
    end
  end

  // Advance pointers and the position within the head pair
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      sub_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push_i) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + PW'(1);
      if (xfer) sub_q <= !pop;
    end
  end

endmodule

>>> rtl/core/pgmp_checker.sv
// Port-level checks for the greymap text parser, bound to its top level.
module pgmp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input pgmp_pkg::pgmp_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pgmp_pkg::pgmp_out_t out_data_o
);
  import pgmp_pkg::*;

  // A stalled byte holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input byte changed");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A status always closes the results of its byte
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind == KIND_STATUS) |-> out_data_o.last_result)
    else $error("status result not marked last");

  // Only pixels carry a position
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.kind != KIND_PIXEL) |->
      (out_data_o.column == '0) && (out_data_o.row == '0))
    else $error("position on a non-pixel result");

  // The second result of a byte follows at once
  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_result |=> out_valid_o)
    else $error("second result of a byte missing");

endmodule

bind pgm_ascii_stream_parser_core pgmp_checker u_checker (.*);

>>> tb/sv/greymap_check_pkg.sv
// Parser prediction and result checking for the greymap text parser testbench.
package greymap_check_pkg;
  import pgmp_pkg::*;

  // Limits the block under test is built with
  localparam int IMG_MAX_W = 4096;
  localparam int IMG_MAX_H = 4096;
  localparam int PIX_BITS  = 16;
  localparam longint PIX_CEIL = (64'd1 << PIX_BITS) - 1;
  localparam logic [63:0] MAG_SAT = 64'hFFFF_FFFF;

  typedef enum logic [2:0] {
    WANT_P, WANT_2, GET_WIDTH, GET_HEIGHT, GET_MAXVAL, GET_PIXELS, TRAILER, DISCARD
  } parse_phase_e;

  class greymap_checker;
    // Parser state
    parse_phase_e phase;
    bit           in_num;
    bit           neg_sign;
    bit           got_digit;
    bit           overflow;
    logic [63:0]  mag;
    logic [31:0]  img_w;
    logic [31:0]  img_h;
    logic [31:0]  max_val;
    logic [31:0]  col;
    logic [31:0]  row;

    pgmp_out_t    byte_results[$];
    pgmp_out_t    pending_results[$];
    int           errors;
    int           live_bytes;

    function new();
      restart();
      errors     = 0;
      live_bytes = 0;
    endfunction

    function void restart();
      phase     = WANT_P;
      in_num    = 1'b0;
      neg_sign  = 1'b0;
      got_digit = 1'b0;
      overflow  = 1'b0;
      mag       = '0;
      img_w     = '0;
      img_h     = '0;
      max_val   = '0;
      col       = '0;
      row       = '0;
    endfunction

    // Queue one result for the current byte; at most two per byte survive
    function void push_res(logic [1:0] kind, logic [63:0] value, logic [31:0] c,
                           logic [31:0] r, logic [31:0] w, logic [31:0] h,
                           logic [1:0] code);
      pgmp_out_t res;
      if (byte_results.size() >= 2) return;
      res.kind         = kind;
      res.value        = value[15:0];
      res.column       = c[11:0];
      res.row          = r[11:0];
      res.image_width  = w[12:0];
      res.image_height = h[12:0];
      res.status       = code;
      res.last_result  = 1'b0;
      byte_results.push_back(res);
    endfunction

    function void abort(logic [1:0] code);
      push_res(KIND_STATUS, '0, '0, '0, '0, '0, code);
      phase  = DISCARD;
      in_num = 1'b0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Close the number in progress; report 0 when it raised an error
    function bit close_number();
      bit neg_val;
      neg_val = neg_sign && (mag != 0);
      in_num  = 1'b0;
      if (!got_digit) begin
        abort(ST_FORMAT);
        return 1'b0;
      end
      case (phase)
        GET_WIDTH, GET_HEIGHT: begin
          if (neg_sign || mag == 0) begin
            abort(ST_FORMAT);
            return 1'b0;
          end
          if (phase == GET_WIDTH) begin
            if (overflow || mag > IMG_MAX_W) begin
              abort(ST_SIZE);
              return 1'b0;
            end
            img_w = mag[31:0];
            phase = GET_HEIGHT;
          end else begin
            if (overflow || mag > IMG_MAX_H) begin
              abort(ST_SIZE);
              return 1'b0;
            end
            img_h = mag[31:0];
            phase = GET_MAXVAL;
          end
          return 1'b1;
        end
        GET_MAXVAL: begin
          if (neg_val) begin
            abort(ST_FORMAT);
            return 1'b0;
          end
          if (overflow || mag > PIX_CEIL) begin
            abort(ST_SIZE);
            return 1'b0;
          end
          max_val = mag[31:0];
          push_res(KIND_HEADER, mag, '0, '0, img_w, img_h, ST_OK);
          col   = '0;
          row   = '0;
          phase = GET_PIXELS;
          return 1'b1;
        end
        default: begin
          if (neg_val || overflow || mag > max_val) begin
            abort(ST_FORMAT);
            return 1'b0;
          end
          push_res(KIND_PIXEL, mag, col, row, '0, '0, ST_OK);
          col++;
          if (col >= img_w) begin
            col = '0;
            row++;
            if (row >= img_h) phase = TRAILER;
          end
          return 1'b1;
        end
      endcase
    endfunction

    // Advance the parser by one character; a terminating character is looked at again
    function void parse_char(logic [7:0] c);
      bit dig;
      bit blank;
      dig   = (c >= CH_ZERO) && (c <= CH_NINE);
      blank = is_blank(c);
      forever begin
        case (phase)
          WANT_P: begin
            if (c == CH_P) phase = WANT_2;
            else abort(ST_FORMAT);
            return;
          end
          WANT_2: begin
            if (c == CH_2) phase = GET_WIDTH;
            else abort(ST_FORMAT);
            return;
          end
          TRAILER: begin
            if (!blank) abort(ST_FORMAT);
            return;
          end
          DISCARD: return;
          default: ;
        endcase
        if (in_num) begin
          if (dig) begin
            mag = mag * 10 + 64'(c - CH_ZERO);
            if (mag > MAG_SAT) begin
              mag      = MAG_SAT;
              overflow = 1'b1;
            end
            got_digit = 1'b1;
            return;
          end
          if (!close_number()) return;
        end else begin
          if (blank) return;
          if (c == CH_PLUS || c == CH_MINUS || dig) begin
            in_num    = 1'b1;
            neg_sign  = (c == CH_MINUS);
            got_digit = dig;
            mag       = dig ? 64'(c - CH_ZERO) : 64'd0;
            overflow  = 1'b0;
            return;
          end
          abort(ST_FORMAT);
          return;
        end
      end
    endfunction

    // Work out the results of one accepted transfer and queue them
    function void note_byte(pgmp_in_t item);
      bit fine;
      pgmp_out_t res;
      byte_results.delete();
      if (phase != DISCARD) live_bytes++;
      parse_char(item.byte_in);
      if (item.end_of_file) begin
        if (phase != DISCARD) begin
          fine = 1'b1;
          if (in_num) fine = close_number();
          if (fine) begin
            if (phase == TRAILER) push_res(KIND_STATUS, '0, '0, '0, '0, '0, ST_OK);
            else abort(ST_FORMAT);
          end
        end
        restart();
      end
      foreach (byte_results[i]) begin
        res             = byte_results[i];
        res.last_result = (i == byte_results.size() - 1);
        pending_results.push_back(res);
      end
    endfunction

    task report(string what);
      if (errors < 100) $display("MISMATCH: %s", what);
      errors++;
    endtask

    // Compare one result transfer with the oldest pending one
    task check_result(pgmp_out_t got);
      pgmp_out_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending: kind %0d value %0d",
                         got.kind, got.value));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.value !== want.value)
        report($sformatf("value %0d, want %0d", got.value, want.value));
      if (got.column !== want.column)
        report($sformatf("column %0d, want %0d", got.column, want.column));
      if (got.row !== want.row)
        report($sformatf("row %0d, want %0d", got.row, want.row));
      if (got.image_width !== want.image_width)
        report($sformatf("image_width %0d, want %0d", got.image_width, want.image_width));
      if (got.image_height !== want.image_height)
        report($sformatf("image_height %0d, want %0d", got.image_height, want.image_height));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.last_result !== want.last_result)
        report($sformatf("last_result %0d, want %0d", got.last_result, want.last_result));
    endtask
  endclass

endpackage

>>> tb/sv/pgm_ascii_stream_parser_core_test.sv
// Self-checking testbench for the greymap text parser core.
module pgm_ascii_stream_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pgmp_pkg::*;
  import greymap_check_pkg::*;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_VT = 8'h0B;
  localparam logic [7:0] CH_FF = 8'h0C;
  // Stands for a number far beyond every limit
  localparam longint HUGE_NUM = -64'sd1000000;
  localparam int RANDOM_BYTES = 1450;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  pgmp_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  pgmp_out_t out_data;

  greymap_checker sb;
  logic [7:0]     text_q[$];
  bit             send_calm;
  bit             recv_calm;
  int             hold_req;

  pgm_ascii_stream_parser_core #(
    .MAX_WIDTH  (IMG_MAX_W),
    .MAX_HEIGHT (IMG_MAX_H),
    .VALUE_BITS (PIX_BITS)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Offer one byte after a random gap and hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input bit eof);
    int gap;
    gap = send_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.byte_in     = b;
    in_data.end_of_file = eof;
    in_valid            = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_byte(in_data);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_file();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
  endtask

  task automatic send_text(input string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    send_file();
  endtask

  task automatic wait_drained();
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      3: return CH_VT;
      4: return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  // Separate numbers by whitespace; a sign may also end the previous number
  function automatic void put_sep(bit signed_next);
    if (signed_next && $urandom_range(0, 2) == 0) return;
    repeat ($urandom_range(1, 3)) text_q.push_back(blank_char());
  endfunction

  function automatic void put_digits(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void put_number(longint v);
    logic [7:0] sign;
    longint     m;
    sign = 8'h00;
    m    = (v < 0) ? -v : v;
    if (v == HUGE_NUM) begin
      if ($urandom_range(0, 3) == 0) sign = CH_PLUS;
      put_sep(sign != 8'h00);
      if (sign != 8'h00) text_q.push_back(sign);
      text_q.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
      repeat ($urandom_range(9, 22)) text_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
      return;
    end
    if (v < 0) sign = CH_MINUS;
    else if (v == 0 && $urandom_range(0, 5) == 0) sign = CH_MINUS;
    else if ($urandom_range(0, 5) == 0) sign = CH_PLUS;
    put_sep(sign != 8'h00);
    if (sign != 8'h00) text_q.push_back(sign);
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) text_q.push_back(CH_ZERO);
    put_digits($sformatf("%0d", m));
  endfunction

  function automatic longint pick_maxval();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return 9;
      3: return 255;
      4: return PIX_CEIL;
      5: return $urandom_range(0, 65535);
      6: return $urandom_range(0, 20);
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  function automatic longint pick_pixel(longint maxv);
    longint v;
    case ($urandom_range(0, 9))
      0: v = 0;
      1: v = maxv;
      default: v = $urandom_range(0, 32'(maxv));
    endcase
    // now and then a pixel out of range
    if ($urandom_range(0, 59) == 0)
      v = $urandom_range(0, 1) ? maxv + 1 : -longint'($urandom_range(1, 9));
    return v;
  endfunction

  function automatic longint pick_dim();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return -longint'($urandom_range(1, 5));
      2: return 4096;
      3: return 4097;
      4: return HUGE_NUM;
      default: return $urandom_range(1, 4);
    endcase
  endfunction

  // Build a greymap with random content; now and then a pixel is out of range
  function automatic void build_clean();
    longint w;
    longint h;
    longint maxv;
    w    = $urandom_range(1, 6);
    h    = $urandom_range(1, 3);
    maxv = pick_maxval();
    text_q.delete();
    text_q.push_back(CH_P);
    text_q.push_back(CH_2);
    put_number(w);
    put_number(h);
    put_number(maxv);
    repeat (w * h) put_number(pick_pixel(maxv));
    repeat ($urandom_range(0, 3)) text_q.push_back(blank_char());
  endfunction

  // Break a built greymap: overwrite a byte, cut it short or add junk after it
  function automatic void corrupt();
    int k;
    case ($urandom_range(0, 2))
      0: text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
      1: begin
        k      = $urandom_range(1, text_q.size());
        text_q = text_q[0:k-1];
      end
      default: begin
        text_q.push_back(8'($urandom_range(CH_SPACE + 1, 255)));
        repeat ($urandom_range(0, 2)) text_q.push_back(blank_char());
      end
    endcase
  endfunction

  // Header values at and beyond the limits, ended after at most three pixels
  function automatic void build_bounds();
    text_q.delete();
    text_q.push_back(CH_P);
    text_q.push_back(CH_2);
    put_number(pick_dim());
    put_number(pick_dim());
    case ($urandom_range(0, 4))
      0: put_number(-longint'($urandom_range(1, 9)));
      1: put_number(PIX_CEIL + 1);
      2: put_number(HUGE_NUM);
      3: put_number(PIX_CEIL);
      default: put_number(0);
    endcase
    repeat ($urandom_range(0, 3)) put_number($urandom_range(0, 9));
  endfunction

  function automatic void build_noise();
    text_q.delete();
    if ($urandom_range(0, 1)) text_q.push_back(CH_P);
    repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Result side: random stall per result, long hold-off on request
  initial begin : receiver
    int hold;
    wait (rst_n);
    forever begin
      if (hold_req > 0) begin
        hold     = hold_req;
        hold_req = 0;
      end else begin
        hold = recv_calm ? 0 : $urandom_range(0, 5);
      end
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int file_no;
    int pick;
    int base;
    sb        = new();
    send_calm = 1'b0;
    recv_calm = 1'b0;
    hold_req  = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed files: minimal image ending on a digit, extreme bytes,
    // negative width, signed oversize width, minus zero and sign as terminator
    send_text("P2 1 1 0 0");
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_text("P2-1");
    send_text("P2+5000");
    send_text("P2 2 1 3 -0+4");
    wait_drained();

    // Random files until enough bytes have reached the parser outside the discard phase
    base    = sb.live_bytes;
    file_no = 0;
    while (sb.live_bytes - base < RANDOM_BYTES) begin
      file_no++;
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
      if (file_no % 40 == 7) hold_req = 150;
      if (file_no % 25 == 0) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        build_clean();
      end else if (pick < 80) begin
        build_clean();
        corrupt();
      end else if (pick < 92) begin
        build_bounds();
      end else begin
        build_noise();
      end
      send_file();
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (sb.pending_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));
    if (sb.errors == 0) begin
      $display("pgm_ascii_stream_parser_core verification clean");
    end else begin
      $display("pgm_ascii_stream_parser_core verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("pgm_ascii_stream_parser_core verification failed");
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/pgmp_pkg.sv
rtl/core/pgmp_engine.sv
rtl/core/pgmp_pair_fifo.sv
rtl/core/pgm_ascii_stream_parser_core.sv
rtl/core/pgmp_checker.sv
tb/sv/greymap_check_pkg.sv
tb/sv/pgm_ascii_stream_parser_core_test.sv
